/* design/assert_macros.svh */
// ------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms; empty when SYNTHESIS is defined.
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// a holds -> b holds in the same cycle
`define ASSERT_SAME(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// a holds -> b holds in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`else

`define ASSERT_SAME(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)

`endif

`endif

/* design/icr_pkg.sv */
// ------------------------------------------------------------------------
// icr_pkg
// Types and constants of the inode cache refcount core.
// ------------------------------------------------------------------------
package icr_pkg;

    localparam int ICR_TABLE_ENTRIES   = 64;
    localparam int ICR_INODE_AREA_BASE = 2;

    localparam int SLOT_W  = 6;
    localparam int DEV_W   = 8;
    localparam int INO_W   = 16;
    localparam int CNT_W   = 8;
    localparam int BLK_W   = 24;
    localparam int IDXB_W  = 8;

    typedef enum logic [1:0] {
        OP_GET  = 2'd0,
        OP_PUT  = 2'd1,
        OP_DUP  = 2'd2,
        OP_MARK = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STS_OK        = 2'd0,
        STS_FULL      = 2'd1,
        STS_UNDERFLOW = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ACT_NONE  = 2'd0,
        ACT_READ  = 2'd1,
        ACT_WBACK = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        REG_IPB  = 2'd0,
        REG_IMAP = 2'd1,
        REG_ZMAP = 2'd2
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SLOT,
        ST_DIV,
        ST_FIN
    } state_t;

    // one table entry as stored in the memory
    typedef struct packed {
        logic             valid;
        logic [DEV_W-1:0] device;
        logic [INO_W-1:0] inode;
        logic [CNT_W-1:0] count;
        logic             dirty;
    } entry_t;

endpackage

/* design/icr_table.sv */
// ------------------------------------------------------------------------
// icr_table
// Entry memory, one read and one write port, registered read data.
// Clears itself after reset, one entry per cycle.
// ------------------------------------------------------------------------
module icr_table
    import icr_pkg::*;
#(
    parameter int TABLE_ENTRIES = ICR_TABLE_ENTRIES,
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [IDX_W-1:0] rd_addr,
    output entry_t           rd_data,
    input  logic             wr_en,
    input  logic [IDX_W-1:0] wr_addr,
    input  entry_t           wr_data,
    output logic             clr_busy
);

    entry_t           mem [TABLE_ENTRIES];
    logic             clr_busy_reg;
    logic             clr_busy_next;
    logic [IDX_W-1:0] clr_addr_reg;
    logic [IDX_W-1:0] clr_addr_next;
    logic             we;
    logic [IDX_W-1:0] wa;
    entry_t           wd;

    always_comb
    begin
        clr_addr_next = clr_addr_reg + 1'b1;
        clr_busy_next = clr_busy_reg &&
                        (clr_addr_reg != IDX_W'(TABLE_ENTRIES - 1));
        we = clr_busy_reg || wr_en;
        wa = clr_busy_reg ? clr_addr_reg : wr_addr;
        wd = clr_busy_reg ? '0 : wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            clr_busy_reg <= clr_busy_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

    assign clr_busy = clr_busy_reg;

endmodule

/* design/icr_div.sv */
// ------------------------------------------------------------------------
// icr_div
// Restoring divider, 16 by 8 bits, one quotient bit per cycle.
// ------------------------------------------------------------------------
module icr_div
    import icr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [INO_W-1:0]  dividend,
    input  logic [IDXB_W-1:0] divisor,
    output logic              done,
    output logic [INO_W-1:0]  quotient,
    output logic [IDXB_W-1:0] remainder
);

    localparam int STEP_W = $clog2(INO_W + 1);

    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              done_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [INO_W-1:0]  quo_reg;
    logic [INO_W-1:0]  quo_next;
    logic [IDXB_W-1:0] rem_reg;
    logic [IDXB_W-1:0] rem_next;
    logic [IDXB_W-1:0] dvs_reg;
    logic [IDXB_W-1:0] dvs_next;
    logic [IDXB_W:0]   trial;
    logic [IDXB_W:0]   diff;

    always_comb
    begin
        trial     = {rem_reg, quo_reg[INO_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = (divisor == '0) ? IDXB_W'(1) : divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[IDXB_W])
            begin
                rem_next = diff[IDXB_W-1:0];
                quo_next = {quo_reg[INO_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[IDXB_W-1:0];
                quo_next = {quo_reg[INO_W-2:0], 1'b0};
            end
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(INO_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

/* design/inode_cache_refcount_core.sv */
// ------------------------------------------------------------------------
// inode_cache_refcount_core
// Reference-counted inode cache: entry table in memory, key scan, disk
// address by iterative division.
// ------------------------------------------------------------------------
// Sequence: get scans the table, then runs the divider when a disk request
//   goes out, then loads the result. put/dup/mark read their slot, then run
//   the divider for a write-back; a slot beyond the table goes straight to the result.
// Throughput: one word at a time; the table scan (one memory read per entry)
//   and the bit-serial divider set the rate.
// Reset: control clears at once; then a clearing pass over every entry
//   zeroes the table, s_tready low meanwhile. Config registers reset to 32/1/1.
module inode_cache_refcount_core
    import icr_pkg::*;
#(
    parameter int TABLE_ENTRIES   = ICR_TABLE_ENTRIES,
    parameter int INODE_AREA_BASE = ICR_INODE_AREA_BASE
)
(
    input  logic        clk,
    input  logic        rst_n,
    // input words
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // opcode[1:0] device[9:2] inode_number[25:10] slot[31:26]
    // result words
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // entry_slot[5:0] status[7:6] disk_action[9:8]
                                   // disk_device[17:10] disk_block[41:18]
                                   // disk_index[49:42] reference_count[57:50], zero above
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

`include "assert_macros.svh"

    localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int SCAN_W = IDX_W + 1;
    localparam int SUM_W  = BLK_W + 1;

    // ---------------- configuration registers ----------------
    logic [7:0]  ipb_reg;
    logic [15:0] imap_reg;
    logic [15:0] zmap_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ipb_reg  <= 8'd32;
            imap_reg <= 16'd1;
            zmap_reg <= 16'd1;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_IPB:  ipb_reg  <= pwdata[7:0];
                REG_IMAP: imap_reg <= pwdata[15:0];
                REG_ZMAP: zmap_reg <= pwdata[15:0];
                default:  ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_IPB:  prdata = {24'd0, ipb_reg};
            REG_IMAP: prdata = {16'd0, imap_reg};
            REG_ZMAP: prdata = {16'd0, zmap_reg};
            default:  prdata = '0;
        endcase
    end

    // ---------------- input fields ----------------
    logic [1:0]        in_op;
    logic [DEV_W-1:0]  in_dev;
    logic [INO_W-1:0]  in_ino;
    logic [SLOT_W-1:0] in_slot;
    logic              accept;

    assign in_op   = s_tdata[1:0];
    assign in_dev  = s_tdata[9:2];
    assign in_ino  = s_tdata[25:10];
    assign in_slot = s_tdata[31:26];

    // ---------------- control and datapath registers ----------------
    state_t            state_reg, state_next;
    logic [1:0]        op_reg, op_next;
    logic [DEV_W-1:0]  dev_reg, dev_next;
    logic [INO_W-1:0]  ino_reg, ino_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [SCAN_W-1:0] scan_addr_reg, scan_addr_next;
    logic              chk_vld_reg, chk_vld_next;
    logic [IDX_W-1:0]  chk_idx_reg, chk_idx_next;
    logic              idle_fnd_reg, idle_fnd_next;
    logic [IDX_W-1:0]  idle_idx_reg, idle_idx_next;
    logic [SLOT_W-1:0] res_slot_reg, res_slot_next;
    logic [1:0]        res_status_reg, res_status_next;
    logic [1:0]        res_action_reg, res_action_next;
    logic [DEV_W-1:0]  res_dev_reg, res_dev_next;
    logic [CNT_W-1:0]  res_count_reg, res_count_next;
    logic              m_valid_reg;
    logic [63:0]       m_data_reg;

    // table and divider hookup
    logic             tbl_rd_en;
    logic [IDX_W-1:0] tbl_rd_addr;
    entry_t           tbl_rd_data;
    logic             tbl_wr_en;
    logic [IDX_W-1:0] tbl_wr_addr;
    entry_t           tbl_wr_data;
    logic             tbl_clr_busy;
    logic              div_start;
    logic [INO_W-1:0]  div_ino;
    logic              div_done;
    logic [INO_W-1:0]  div_quo;
    logic [IDXB_W-1:0] div_rem;

    // decision flags of the control blocks
    logic decide;
    logic need_disk;
    logic slot_oob;
    logic out_free;
    logic hit;
    logic cur_idle;
    logic last_chk;

    icr_table #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .rd_en    (tbl_rd_en),
        .rd_addr  (tbl_rd_addr),
        .rd_data  (tbl_rd_data),
        .wr_en    (tbl_wr_en),
        .wr_addr  (tbl_wr_addr),
        .wr_data  (tbl_wr_data),
        .clr_busy (tbl_clr_busy)
    );

    icr_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_ino - 1'b1),
        .divisor   (ipb_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign s_tready = (state_reg == ST_IDLE) && !tbl_clr_busy;
    assign accept   = s_tvalid && s_tready;
    assign slot_oob = 32'(in_slot) >= 32'(TABLE_ENTRIES);
    assign out_free = !m_valid_reg || m_tready;

    // scan compare on the entry read last cycle
    assign hit      = chk_vld_reg && tbl_rd_data.valid &&
                      (tbl_rd_data.device == dev_reg) && (tbl_rd_data.inode == ino_reg);
    assign cur_idle = !tbl_rd_data.valid || (tbl_rd_data.count == '0);
    assign last_chk = chk_vld_reg && (chk_idx_reg == IDX_W'(TABLE_ENTRIES - 1));

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (op_t'(in_op) == OP_GET)
                    begin
                        state_next = ST_SCAN;
                    end
                    else if (slot_oob)
                    begin
                        state_next = ST_FIN;
                    end
                    else
                    begin
                        state_next = ST_SLOT;
                    end
                end
            end
            ST_SCAN, ST_SLOT:
            begin
                if (decide)
                begin
                    state_next = need_disk ? ST_DIV : ST_FIN;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ---------------- datapath and memory control ----------------
    always_comb
    begin
        entry_t e;
        e = tbl_rd_data;

        op_next         = op_reg;
        dev_next        = dev_reg;
        ino_next        = ino_reg;
        slot_next       = slot_reg;
        scan_addr_next  = scan_addr_reg;
        chk_vld_next    = 1'b0;
        chk_idx_next    = chk_idx_reg;
        idle_fnd_next   = idle_fnd_reg;
        idle_idx_next   = idle_idx_reg;
        res_slot_next   = res_slot_reg;
        res_status_next = res_status_reg;
        res_action_next = res_action_reg;
        res_dev_next    = res_dev_reg;
        res_count_next  = res_count_reg;
        tbl_rd_en       = 1'b0;
        tbl_rd_addr     = IDX_W'(in_slot);
        tbl_wr_en       = 1'b0;
        tbl_wr_addr     = chk_idx_reg;
        tbl_wr_data     = e;
        decide          = 1'b0;
        need_disk       = 1'b0;
        div_start       = 1'b0;
        div_ino         = ino_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    op_next         = in_op;
                    dev_next        = in_dev;
                    ino_next        = in_ino;
                    slot_next       = in_slot;
                    scan_addr_next  = '0;
                    idle_fnd_next   = 1'b0;
                    res_slot_next   = in_slot;
                    res_status_next = STS_OK;
                    res_action_next = ACT_NONE;
                    res_count_next  = '0;
                    // slot ops fetch their entry now
                    tbl_rd_en = (op_t'(in_op) != OP_GET) && !slot_oob;
                end
            end
            ST_SCAN:
            begin
                // one read per cycle; the compare works on the registered read data
                tbl_rd_en      = scan_addr_reg < SCAN_W'(TABLE_ENTRIES);
                tbl_rd_addr    = scan_addr_reg[IDX_W-1:0];
                scan_addr_next = scan_addr_reg + 1'b1;
                chk_vld_next   = tbl_rd_en;
                chk_idx_next   = scan_addr_reg[IDX_W-1:0];
                if (chk_vld_reg && !idle_fnd_reg && cur_idle)
                begin
                    idle_fnd_next = 1'b1;
                    idle_idx_next = chk_idx_reg;
                end
                if (hit)
                begin
                    decide = 1'b1;
                    if (e.count == '0 && e.dirty)
                    begin
                        e.dirty         = 1'b0;
                        res_action_next = ACT_WBACK;
                        need_disk       = 1'b1;
                    end
                    if (e.count != '1)
                    begin
                        e.count = e.count + 1'b1;
                    end
                    tbl_wr_en      = 1'b1;
                    tbl_wr_addr    = chk_idx_reg;
                    tbl_wr_data    = e;
                    res_slot_next  = SLOT_W'(chk_idx_reg);
                    res_count_next = e.count;
                    res_dev_next   = dev_reg;
                end
                else if (last_chk)
                begin
                    decide = 1'b1;
                    if (idle_fnd_reg || cur_idle)
                    begin
                        // claim: reclaimed dirty data is dropped
                        tbl_wr_en         = 1'b1;
                        tbl_wr_addr       = idle_fnd_reg ? idle_idx_reg : chk_idx_reg;
                        tbl_wr_data.valid = 1'b1;
                        tbl_wr_data.device = dev_reg;
                        tbl_wr_data.inode = ino_reg;
                        tbl_wr_data.count = CNT_W'(1);
                        tbl_wr_data.dirty = 1'b0;
                        res_slot_next     = SLOT_W'(tbl_wr_addr);
                        res_count_next    = CNT_W'(1);
                        res_action_next   = ACT_READ;
                        res_dev_next      = dev_reg;
                        need_disk         = 1'b1;
                    end
                    else
                    begin
                        res_slot_next   = '0;
                        res_status_next = STS_FULL;
                        res_count_next  = '0;
                    end
                end
                div_ino = ino_reg;
            end
            ST_SLOT:
            begin
                decide      = 1'b1;
                tbl_wr_addr = IDX_W'(slot_reg);
                case (op_t'(op_reg))
                    OP_PUT:
                    begin
                        if (e.count == '0)
                        begin
                            res_status_next = STS_UNDERFLOW;
                        end
                        else
                        begin
                            e.count = e.count - 1'b1;
                            if (e.count == '0)
                            begin
                                e.dirty         = 1'b0;
                                res_action_next = ACT_WBACK;
                                res_dev_next    = e.device;
                                need_disk       = 1'b1;
                            end
                            tbl_wr_en = 1'b1;
                        end
                    end
                    OP_DUP:
                    begin
                        if (e.valid && e.count != '1)
                        begin
                            e.count   = e.count + 1'b1;
                            tbl_wr_en = 1'b1;
                        end
                    end
                    OP_MARK:
                    begin
                        if (e.valid)
                        begin
                            e.dirty   = 1'b1;
                            tbl_wr_en = 1'b1;
                        end
                    end
                    default: ;
                endcase
                tbl_wr_data    = e;
                res_count_next = e.count;
                div_ino        = e.inode;
            end
            default: ;
        endcase

        div_start = decide && need_disk;
    end

    // ---------------- disk address ----------------
    logic [SUM_W-1:0] blk_sum;
    logic [BLK_W-1:0] blk;
    logic [39:0]      disk_bits;   // disk_device, disk_block, disk_index from the low bit up

    assign blk_sum = SUM_W'(div_quo) + SUM_W'(INODE_AREA_BASE)
                   + SUM_W'(imap_reg) + SUM_W'(zmap_reg);
    assign blk     = blk_sum[BLK_W] ? '1 : blk_sum[BLK_W-1:0];

    // disk fields only travel with a disk request
    assign disk_bits = (action_t'(res_action_reg) != ACT_NONE) ?
                       {div_rem, blk, res_dev_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            chk_vld_reg   <= 1'b0;
            idle_fnd_reg  <= 1'b0;
            scan_addr_reg <= '0;
            m_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            chk_vld_reg   <= chk_vld_next;
            idle_fnd_reg  <= idle_fnd_next;
            scan_addr_reg <= scan_addr_next;
            if (state_reg == ST_FIN && out_free)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        dev_reg        <= dev_next;
        ino_reg        <= ino_next;
        slot_reg       <= slot_next;
        chk_idx_reg    <= chk_idx_next;
        idle_idx_reg   <= idle_idx_next;
        res_slot_reg   <= res_slot_next;
        res_status_reg <= res_status_next;
        res_action_reg <= res_action_next;
        res_dev_reg    <= res_dev_next;
        res_count_reg  <= res_count_next;
        if (state_reg == ST_FIN && out_free)
        begin
            m_data_reg <= {6'd0, res_count_reg, disk_bits,
                           res_action_reg, res_status_reg, res_slot_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // ---------------- assertions ----------------
    // one word in flight: nothing accepted right after an accept
    `ASSERT_NEXT(a_one_in_flight, clk, rst_n, accept, !s_tready)
    // divider finishes only while the FSM waits on it
    `ASSERT_SAME(a_div_owned, clk, rst_n, div_done, state_reg == ST_DIV)
    // table full never comes with a disk request
    `ASSERT_SAME(a_full_no_disk, clk, rst_n, m_valid_reg && m_data_reg[7:6] == STS_FULL,
                 m_data_reg[9:8] == ACT_NONE)
    // no input while the table clears
    `ASSERT_SAME(a_clear_blocks, clk, rst_n, tbl_clr_busy, !s_tready)

endmodule
